// File: design/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg: shared types and constants of the console line editor
// Item classes, character codes and the front-to-back item type.
// ----------------------------------------------------------------------------
package cle_pkg;

   localparam logic [2:0] OP_READ  = 3'd0;
   localparam logic [2:0] OP_DUMP  = 3'd1;
   localparam logic [2:0] OP_KILL  = 3'd2;
   localparam logic [2:0] OP_ERASE = 3'd3;
   localparam logic [2:0] OP_ESC   = 3'd4;
   localparam logic [2:0] OP_NUL   = 3'd5;
   localparam logic [2:0] OP_CHAR  = 3'd6;

   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_BS   = 8'h08;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_EOT  = 8'h04;
   localparam logic [7:0] CH_DLE  = 8'h10;
   localparam logic [7:0] CH_NAK  = 8'h15;
   localparam logic [7:0] CH_ESC  = 8'h1B;
   localparam logic [7:0] CH_DEL  = 8'h7F;
   localparam logic [7:0] CH_LBRK = 8'h5B;
   localparam logic [7:0] CH_UP   = 8'h41;
   localparam logic [7:0] CH_DOWN = 8'h42;

   localparam logic [1:0] ESC_NONE = 2'd0;
   localparam logic [1:0] ESC_SEEN = 2'd1;
   localparam logic [1:0] ESC_BRKT = 2'd2;

   // "history", first letter at index 0
   function automatic logic [7:0] hist_word(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0: c = 8'h68;
         3'd1: c = 8'h69;
         3'd2: c = 8'h73;
         3'd3: c = 8'h74;
         3'd4: c = 8'h6F;
         3'd5: c = 8'h72;
         3'd6: c = 8'h79;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] data;
      logic       started;
   } item_type;

endpackage

// File: design/cle_ram.sv
// ----------------------------------------------------------------------------
// cle_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/cle_front.sv
// ----------------------------------------------------------------------------
// cle_front: input classification and item queue
// Classifies each accepted item and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module cle_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [7:0]        req_rx_byte,
   input  logic              req_read_started,
   output logic              item_valid,
   output cle_pkg::item_type item,
   input  logic              item_ready
);

   cle_pkg::item_type q_ff [2];
   cle_pkg::item_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   cle_pkg::item_type cls;
   logic push, pop;

   always_comb begin
      cls.started = req_read_started;
      cls.data    = (req_rx_byte == cle_pkg::CH_CR) ? cle_pkg::CH_LF : req_rx_byte;
      if (req_kind) begin
         cls.op = cle_pkg::OP_READ;
      end else begin
         unique case (req_rx_byte)
            cle_pkg::CH_DLE: cls.op = cle_pkg::OP_DUMP;
            cle_pkg::CH_NAK: cls.op = cle_pkg::OP_KILL;
            cle_pkg::CH_BS:  cls.op = cle_pkg::OP_ERASE;
            cle_pkg::CH_DEL: cls.op = cle_pkg::OP_ERASE;
            cle_pkg::CH_ESC: cls.op = cle_pkg::OP_ESC;
            cle_pkg::CH_NUL: cls.op = cle_pkg::OP_NUL;
            default:         cls.op = cle_pkg::OP_CHAR;
         endcase
      end
   end

   assign req_ready  = (cnt_ff != 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[0];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push) begin
         if (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop)) begin
            q_in[0] = cls;
         end else begin
            q_in[1] = cls;
         end
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

endmodule

// File: design/cle_back.sv
// ----------------------------------------------------------------------------
// cle_back: editing engine
// Sequencer over the line buffer, history store and result register.
// ----------------------------------------------------------------------------
module cle_back #(
   parameter int BUF_DEPTH    = 128,
   parameter int HIST_ENTRIES = 16,
   parameter int LINE_LEN     = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  cle_pkg::item_type item,
   output logic              item_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [3:0]        rsp_echo_count,
   output logic [63:0]       rsp_echo_bytes,
   output logic [7:0]        rsp_erase_count,
   output logic              rsp_dump_request,
   output logic              rsp_line_ready,
   output logic              rsp_read_valid,
   output logic [7:0]        rsp_read_byte,
   output logic              rsp_read_eof,
   output logic              rsp_last
);

   localparam int AW   = $clog2(BUF_DEPTH);
   localparam int PW   = AW + 1;
   localparam int PMOD = 2 * BUF_DEPTH;
   localparam int HW   = $clog2(HIST_ENTRIES);
   localparam int CW   = $clog2(HIST_ENTRIES + 1);
   localparam int LW   = $clog2(LINE_LEN + 1);
   localparam int HD   = HIST_ENTRIES * LINE_LEN;
   localparam int HAW  = $clog2(HD);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_KILL     = 5'd1;
   localparam logic [4:0] S_KILL_W   = 5'd2;
   localparam logic [4:0] S_CMT      = 5'd3;
   localparam logic [4:0] S_CHK      = 5'd4;
   localparam logic [4:0] S_CHK_W    = 5'd5;
   localparam logic [4:0] S_CPY      = 5'd6;
   localparam logic [4:0] S_CPY_W    = 5'd7;
   localparam logic [4:0] S_CMT_END  = 5'd8;
   localparam logic [4:0] S_RCL      = 5'd9;
   localparam logic [4:0] S_RCL_LW   = 5'd10;
   localparam logic [4:0] S_RCL_LOOP = 5'd11;
   localparam logic [4:0] S_RCL_W    = 5'd12;
   localparam logic [4:0] S_RCL_PUT  = 5'd13;
   localparam logic [4:0] S_RCL_MV   = 5'd14;
   localparam logic [4:0] S_RDW      = 5'd15;
   localparam logic [4:0] S_FIN      = 5'd16;

   function automatic logic [PW-1:0] p_inc(input logic [PW-1:0] a);
      return (a == PW'(PMOD - 1)) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [PW-1:0] p_dec(input logic [PW-1:0] a);
      return (a == '0) ? PW'(PMOD - 1) : a - 1'b1;
   endfunction

   function automatic logic [PW-1:0] p_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
      logic [PW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (PW+1)'(PMOD)) s = s - (PW+1)'(PMOD);
      return s[PW-1:0];
   endfunction

   function automatic logic [PW-1:0] p_dist(input logic [PW-1:0] a, input logic [PW-1:0] b);
      logic [PW:0] s;
      s = (a >= b) ? {1'b0, a} - {1'b0, b} : {1'b0, a} + (PW+1)'(PMOD) - {1'b0, b};
      return s[PW-1:0];
   endfunction

   function automatic logic [AW-1:0] p_addr(input logic [PW-1:0] p);
      logic [PW-1:0] s;
      s = (p >= PW'(BUF_DEPTH)) ? p - PW'(BUF_DEPTH) : p;
      return s[AW-1:0];
   endfunction

   logic [4:0]    state_ff, state_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in, cm_ptr_ff, cm_ptr_in, ed_ptr_ff, ed_ptr_in;
   logic [HW-1:0] h_next_ff, h_next_in, h_cur_ff, h_cur_in;
   logic [CW-1:0] h_count_ff, h_count_in;
   logic [1:0]    esc_ff, esc_in;
   cle_pkg::item_type it_ff, it_in;
   logic [PW-1:0] len_ff, len_in;
   logic [LW-1:0] j_ff, j_in, cpy_len_ff, cpy_len_in;
   logic [7:0]    byte_ff, byte_in;
   logic [63:0]   echo_ff, echo_in;
   logic [3:0]    ecnt_ff, ecnt_in;
   logic [7:0]    erase_ff, erase_in;
   logic          dump_ff, dump_in, ready_ff, ready_in, first_ff, first_in;
   logic          rv_ff, rv_in, reof_ff, reof_in;
   logic [7:0]    rbyte_ff, rbyte_in;

   logic          o_valid_ff, o_valid_in;
   logic [3:0]    o_ecnt_ff, o_ecnt_in;
   logic [63:0]   o_echo_ff, o_echo_in;
   logic [7:0]    o_erase_ff, o_erase_in;
   logic          o_dump_ff, o_dump_in, o_ready_ff, o_ready_in;
   logic          o_rv_ff, o_rv_in, o_reof_ff, o_reof_in, o_last_ff, o_last_in;
   logic [7:0]    o_rbyte_ff, o_rbyte_in;

   logic           l_we;
   logic [AW-1:0]  l_waddr, l_raddr;
   logic [7:0]     l_wdata, l_rdata;
   logic           h_we;
   logic [HAW-1:0] h_waddr, h_raddr;
   logic [7:0]     h_rdata;
   logic           n_we;
   logic [HW-1:0]  n_raddr;
   logic [LW-1:0]  n_rdata;

   logic out_free, emit, emit_last;
   logic [PW-1:0] e1;
   logic [HW-1:0] top;
   logic [8:0]    len9;

   cle_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_line (
      .clock(clock), .wr_en(l_we), .wr_addr(l_waddr), .wr_data(l_wdata),
      .rd_addr(l_raddr), .rd_data(l_rdata)
   );

   cle_ram #(.WIDTH(8), .DEPTH(HD)) u_hist (
      .clock(clock), .wr_en(h_we), .wr_addr(h_waddr), .wr_data(l_rdata),
      .rd_addr(h_raddr), .rd_data(h_rdata)
   );

   cle_ram #(.WIDTH(LW), .DEPTH(HIST_ENTRIES)) u_hlen (
      .clock(clock), .wr_en(n_we), .wr_addr(h_next_ff), .wr_data(cpy_len_ff),
      .rd_addr(n_raddr), .rd_data(n_rdata)
   );

   assign out_free   = !o_valid_ff || rsp_ready;
   assign item_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      rd_ptr_in  = rd_ptr_ff;
      cm_ptr_in  = cm_ptr_ff;
      ed_ptr_in  = ed_ptr_ff;
      h_next_in  = h_next_ff;
      h_cur_in   = h_cur_ff;
      h_count_in = h_count_ff;
      esc_in     = esc_ff;
      it_in      = it_ff;
      len_in     = len_ff;
      j_in       = j_ff;
      cpy_len_in = cpy_len_ff;
      byte_in    = byte_ff;
      echo_in    = echo_ff;
      ecnt_in    = ecnt_ff;
      erase_in   = erase_ff;
      dump_in    = dump_ff;
      ready_in   = ready_ff;
      first_in   = first_ff;
      rv_in      = rv_ff;
      reof_in    = reof_ff;
      rbyte_in   = rbyte_ff;
      l_we       = 1'b0;
      l_waddr    = p_addr(ed_ptr_ff);
      l_wdata    = byte_ff;
      l_raddr    = '0;
      h_we       = 1'b0;
      h_waddr    = HAW'(HAW'(h_next_ff) * HAW'(LINE_LEN) + HAW'(j_ff));
      h_raddr    = HAW'(HAW'(h_cur_ff) * HAW'(LINE_LEN) + HAW'(j_ff));
      n_we       = 1'b0;
      n_raddr    = h_cur_ff;
      emit       = 1'b0;
      emit_last  = 1'b0;
      e1         = p_inc(ed_ptr_ff);
      top        = (h_next_ff == '0) ? HW'(HIST_ENTRIES - 1) : h_next_ff - 1'b1;
      len9       = 9'(len_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               it_in    = item;
               echo_in  = '0;
               ecnt_in  = '0;
               erase_in = '0;
               dump_in  = 1'b0;
               ready_in = 1'b0;
               first_in = 1'b1;
               rv_in    = 1'b0;
               reof_in  = 1'b0;
               rbyte_in = '0;
               state_in = S_FIN;
               if (item.op == cle_pkg::OP_READ) begin
                  l_raddr = p_addr(rd_ptr_ff);
                  if (rd_ptr_ff != cm_ptr_ff) state_in = S_RDW;
               end else if (esc_ff == cle_pkg::ESC_SEEN) begin
                  esc_in = (item.data == cle_pkg::CH_LBRK) ? cle_pkg::ESC_BRKT
                                                          : cle_pkg::ESC_NONE;
               end else if (esc_ff == cle_pkg::ESC_BRKT) begin
                  esc_in = cle_pkg::ESC_NONE;
                  if (item.data == cle_pkg::CH_UP || item.data == cle_pkg::CH_DOWN) begin
                     state_in = S_RCL;
                  end
               end else begin
                  esc_in = cle_pkg::ESC_NONE;
                  unique case (item.op)
                     cle_pkg::OP_DUMP: dump_in = 1'b1;
                     cle_pkg::OP_KILL: state_in = S_KILL;
                     cle_pkg::OP_ERASE: begin
                        if (ed_ptr_ff != cm_ptr_ff) begin
                           ed_ptr_in = p_dec(ed_ptr_ff);
                           erase_in  = 8'd1;
                        end
                     end
                     cle_pkg::OP_ESC: esc_in = cle_pkg::ESC_SEEN;
                     cle_pkg::OP_CHAR: begin
                        if (p_dist(ed_ptr_ff, rd_ptr_ff) < PW'(BUF_DEPTH)) begin
                           l_we          = 1'b1;
                           l_wdata       = item.data;
                           echo_in[7:0]  = item.data;
                           ecnt_in       = 4'd1;
                           ed_ptr_in     = e1;
                           if (item.data == cle_pkg::CH_LF || item.data == cle_pkg::CH_EOT ||
                               p_dist(e1, rd_ptr_ff) == PW'(BUF_DEPTH)) begin
                              state_in = S_CMT;
                           end
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         S_KILL: begin
            l_raddr = p_addr(p_dec(ed_ptr_ff));
            state_in = (ed_ptr_ff == cm_ptr_ff) ? S_FIN : S_KILL_W;
         end
         S_KILL_W: begin
            if (l_rdata != cle_pkg::CH_LF) begin
               ed_ptr_in = p_dec(ed_ptr_ff);
               erase_in  = erase_ff + 8'd1;
               state_in  = S_KILL;
            end else begin
               state_in = S_FIN;
            end
         end
         S_CMT: begin
            len_in = p_dist(ed_ptr_ff, cm_ptr_ff) - 1'b1;
            j_in   = '0;
            if (p_dist(ed_ptr_ff, cm_ptr_ff) == PW'(1)) state_in = S_CMT_END;
            else if (p_dist(ed_ptr_ff, cm_ptr_ff) >= PW'(8)) state_in = S_CHK;
            else state_in = S_CPY;
         end
         S_CHK: begin
            cpy_len_in = (len9 > 9'(LINE_LEN)) ? LW'(LINE_LEN) : LW'(len_ff);
            l_raddr  = p_addr(p_add(cm_ptr_ff, PW'(j_ff)));
            state_in = S_CHK_W;
         end
         S_CHK_W: begin
            if (l_rdata != cle_pkg::hist_word(j_ff[2:0])) begin
               j_in     = '0;
               state_in = S_CPY;
            end else if (j_ff == LW'(6)) begin
               state_in = S_CMT_END;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_CHK;
            end
         end
         S_CPY: begin
            cpy_len_in = (len9 > 9'(LINE_LEN)) ? LW'(LINE_LEN) : LW'(len_ff);
            l_raddr = p_addr(p_add(cm_ptr_ff, PW'(j_ff)));
            if (j_ff == cpy_len_in) begin
               n_we      = 1'b1;
               h_next_in = (h_next_ff == HW'(HIST_ENTRIES - 1)) ? '0 : h_next_ff + 1'b1;
               h_cur_in  = h_next_in;
               if (h_count_ff != CW'(HIST_ENTRIES)) h_count_in = h_count_ff + 1'b1;
               state_in = S_CMT_END;
            end else begin
               state_in = S_CPY_W;
            end
         end
         S_CPY_W: begin
            h_we     = 1'b1;
            j_in     = j_ff + 1'b1;
            state_in = S_CPY;
         end
         S_CMT_END: begin
            cm_ptr_in = ed_ptr_ff;
            ready_in  = 1'b1;
            state_in  = S_FIN;
         end
         S_RCL: begin
            state_in = (CW'(h_cur_ff) < h_count_ff) ? S_RCL_LW : S_RCL_MV;
         end
         S_RCL_LW: begin
            cpy_len_in = n_rdata;
            erase_in   = 8'(p_dist(ed_ptr_ff, cm_ptr_ff));
            ed_ptr_in  = cm_ptr_ff;
            j_in       = '0;
            state_in   = S_RCL_LOOP;
         end
         S_RCL_LOOP: begin
            if (j_ff == cpy_len_ff || p_dist(ed_ptr_ff, rd_ptr_ff) >= PW'(BUF_DEPTH)) begin
               state_in = S_RCL_MV;
            end else begin
               state_in = S_RCL_W;
            end
         end
         S_RCL_W: begin
            byte_in  = h_rdata;
            state_in = S_RCL_PUT;
         end
         S_RCL_PUT: begin
            if (ecnt_ff == 4'd8) begin
               // chunk full and more follows: ship it without last
               if (out_free) begin
                  emit     = 1'b1;
                  first_in = 1'b0;
                  ecnt_in  = '0;
                  echo_in  = '0;
               end
            end else begin
               echo_in[{ecnt_ff[2:0], 3'b000} +: 8] = byte_ff;
               ecnt_in   = ecnt_ff + 4'd1;
               l_we      = 1'b1;
               ed_ptr_in = e1;
               j_in      = j_ff + 1'b1;
               state_in  = S_RCL_LOOP;
            end
         end
         S_RCL_MV: begin
            if (it_ff.data == cle_pkg::CH_UP) begin
               if (h_cur_ff != '0) h_cur_in = h_cur_ff - 1'b1;
            end else if (h_cur_ff != top) begin
               h_cur_in = (h_cur_ff == HW'(HIST_ENTRIES - 1)) ? '0 : h_cur_ff + 1'b1;
            end
            state_in = S_FIN;
         end
         S_RDW: begin
            rv_in     = 1'b1;
            rd_ptr_in = p_inc(rd_ptr_ff);
            if (l_rdata == cle_pkg::CH_EOT) begin
               reof_in = 1'b1;
               if (it_ff.started) rd_ptr_in = rd_ptr_ff;
            end else begin
               rbyte_in = l_rdata;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      o_valid_in = o_valid_ff && !rsp_ready;
      o_ecnt_in  = o_ecnt_ff;
      o_echo_in  = o_echo_ff;
      o_erase_in = o_erase_ff;
      o_dump_in  = o_dump_ff;
      o_ready_in = o_ready_ff;
      o_rv_in    = o_rv_ff;
      o_rbyte_in = o_rbyte_ff;
      o_reof_in  = o_reof_ff;
      o_last_in  = o_last_ff;
      if (emit) begin
         o_valid_in = 1'b1;
         o_ecnt_in  = ecnt_ff;
         o_echo_in  = echo_ff;
         o_erase_in = first_ff ? erase_in : 8'd0;
         o_dump_in  = first_ff && dump_ff;
         o_ready_in = first_ff && ready_ff;
         o_rv_in    = rv_ff;
         o_rbyte_in = rbyte_ff;
         o_reof_in  = reof_ff;
         o_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rd_ptr_ff  <= '0;
         cm_ptr_ff  <= '0;
         ed_ptr_ff  <= '0;
         h_next_ff  <= '0;
         h_cur_ff   <= '0;
         h_count_ff <= '0;
         esc_ff     <= cle_pkg::ESC_NONE;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_ptr_ff  <= rd_ptr_in;
         cm_ptr_ff  <= cm_ptr_in;
         ed_ptr_ff  <= ed_ptr_in;
         h_next_ff  <= h_next_in;
         h_cur_ff   <= h_cur_in;
         h_count_ff <= h_count_in;
         esc_ff     <= esc_in;
         o_valid_ff <= o_valid_in;
      end
      it_ff      <= it_in;
      len_ff     <= len_in;
      j_ff       <= j_in;
      cpy_len_ff <= cpy_len_in;
      byte_ff    <= byte_in;
      echo_ff    <= echo_in;
      ecnt_ff    <= ecnt_in;
      erase_ff   <= erase_in;
      dump_ff    <= dump_in;
      ready_ff   <= ready_in;
      first_ff   <= first_in;
      rv_ff      <= rv_in;
      reof_ff    <= reof_in;
      rbyte_ff   <= rbyte_in;
      o_ecnt_ff  <= o_ecnt_in;
      o_echo_ff  <= o_echo_in;
      o_erase_ff <= o_erase_in;
      o_dump_ff  <= o_dump_in;
      o_ready_ff <= o_ready_in;
      o_rv_ff    <= o_rv_in;
      o_rbyte_ff <= o_rbyte_in;
      o_reof_ff  <= o_reof_in;
      o_last_ff  <= o_last_in;
   end

   assign rsp_valid        = o_valid_ff;
   assign rsp_echo_count   = o_ecnt_ff;
   assign rsp_echo_bytes   = o_echo_ff;
   assign rsp_erase_count  = o_erase_ff;
   assign rsp_dump_request = o_dump_ff;
   assign rsp_line_ready   = o_ready_ff;
   assign rsp_read_valid   = o_rv_ff;
   assign rsp_read_byte    = o_rbyte_ff;
   assign rsp_read_eof     = o_reof_ff;
   assign rsp_last         = o_last_ff;

endmodule

// File: design/console_line_editor_with_history.sv
// ----------------------------------------------------------------------------
// console_line_editor_with_history: canonical console input editor
// Line buffer with read/commit/edit pointers and a ring of recent lines.
// ----------------------------------------------------------------------------
// Channel | Ports | Direction | Contents
// req     | req_* | in        | kind, rx_byte, read_started
// rsp     | rsp_* | out       | echo, erase, dump, line_ready, read fields, last
//
// One item at a time in the engine; a two-entry queue sits in front of it.
// ^U walks back over the erased bytes one at a time; a commit checks and
// copies the line byte by byte (up to LINE_LEN copied); a recall copies
// the stored line byte by byte and ships its echo in chunks of 8 bytes,
// all through the one read port of the line and history RAMs.
// Reset is synchronous and clears pointers, counters and the escape state.
// A stalled rsp holds the engine at its next result; req keeps accepting
// until the queue fills.
module console_line_editor_with_history #(
   parameter int BUF_DEPTH    = 128,
   parameter int HIST_ENTRIES = 16,
   parameter int LINE_LEN     = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_read_started,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_echo_count,
   output logic [63:0] rsp_echo_bytes,
   output logic [7:0]  rsp_erase_count,
   output logic        rsp_dump_request,
   output logic        rsp_line_ready,
   output logic        rsp_read_valid,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_read_eof,
   output logic        rsp_last
);

   logic              item_valid, item_ready;
   cle_pkg::item_type item;

   cle_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_rx_byte(req_rx_byte), .req_read_started(req_read_started),
      .item_valid(item_valid), .item(item), .item_ready(item_ready)
   );

   cle_back #(
      .BUF_DEPTH(BUF_DEPTH), .HIST_ENTRIES(HIST_ENTRIES), .LINE_LEN(LINE_LEN)
   ) u_back (
      .clock(clock), .reset(reset),
      .item_valid(item_valid), .item(item), .item_ready(item_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_echo_count(rsp_echo_count), .rsp_echo_bytes(rsp_echo_bytes),
      .rsp_erase_count(rsp_erase_count), .rsp_dump_request(rsp_dump_request),
      .rsp_line_ready(rsp_line_ready), .rsp_read_valid(rsp_read_valid),
      .rsp_read_byte(rsp_read_byte), .rsp_read_eof(rsp_read_eof),
      .rsp_last(rsp_last)
   );

endmodule

// File: design/cle_checker.sv
// ----------------------------------------------------------------------------
// cle_props: port-level checks of the console line editor
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module cle_props (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_echo_count,
   input logic [63:0] rsp_echo_bytes,
   input logic        rsp_read_valid,
   input logic [7:0]  rsp_read_byte,
   input logic        rsp_read_eof,
   input logic        rsp_last
);

   // stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_echo_bytes) && $stable(rsp_last))
      else $error("rsp item changed while stalled");

   // a read answer is always a single item
   a_read_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_valid |-> rsp_last && rsp_echo_count == 4'd0)
      else $error("read result not a lone item");

   a_eof: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_eof |-> rsp_read_valid && rsp_read_byte == 8'd0)
      else $error("eof result malformed");

   // a non-final item carries a full chunk of echo
   a_chunk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_echo_count == 4'd8)
      else $error("partial echo chunk before last");

endmodule

bind console_line_editor_with_history cle_props u_cle_props (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_echo_count(rsp_echo_count), .rsp_echo_bytes(rsp_echo_bytes),
   .rsp_read_valid(rsp_read_valid), .rsp_read_byte(rsp_read_byte),
   .rsp_read_eof(rsp_read_eof), .rsp_last(rsp_last)
);

// File: sim/cle_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cle_checker: line editor predictor and result comparator
// Watches both channels, predicts the results of every accepted item from
// its own copy of the editor state, and compares each accepted result with
// the oldest prediction.
// ----------------------------------------------------------------------------
module cle_checker #(
   parameter int BUF_DEPTH    = 128,
   parameter int HIST_ENTRIES = 16,
   parameter int LINE_LEN     = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_read_started,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_echo_count,
   input  logic [63:0] rsp_echo_bytes,
   input  logic [7:0]  rsp_erase_count,
   input  logic        rsp_dump_request,
   input  logic        rsp_line_ready,
   input  logic        rsp_read_valid,
   input  logic [7:0]  rsp_read_byte,
   input  logic        rsp_read_eof,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending,
   output int          results_seen,
   output int          lines_stored,
   output int          recalls_done
);

   localparam int PTR_MOD = 2 * BUF_DEPTH;

   typedef struct packed {
      logic [3:0]  echo_count;
      logic [63:0] echo_bytes;
      logic [7:0]  erase_count;
      logic        dump_request;
      logic        line_ready;
      logic        read_valid;
      logic [7:0]  read_byte;
      logic        read_eof;
      logic        last;
   } editor_rsp_type;

   editor_rsp_type expected_rsps[$];

   logic [7:0] line_mem [BUF_DEPTH];
   logic [7:0] hist_mem [HIST_ENTRIES][LINE_LEN];
   int unsigned hist_size [HIST_ENTRIES];
   int unsigned rd_ptr, cm_ptr, ed_ptr;
   int unsigned h_next, h_count, h_cursor;
   logic [1:0]  esc_state;

   logic [7:0]  echo_q [LINE_LEN + 8];
   int unsigned echo_n, erase_n;
   logic        dump_f, ready_f;
   string       hist_prefix = "history";

   function automatic int unsigned ptr_dist(int unsigned a, int unsigned b);
      return (a + PTR_MOD - b) % PTR_MOD;
   endfunction

   function automatic void push_echo(logic [7:0] c);
      if (echo_n < LINE_LEN + 8) begin
         echo_q[echo_n] = c;
         echo_n++;
      end
   endfunction

   function automatic void put_char(logic [7:0] c);
      line_mem[ed_ptr % BUF_DEPTH] = c;
      ed_ptr = (ed_ptr + 1) % PTR_MOD;
   endfunction

   function automatic void commit_line();
      int unsigned len;
      int unsigned slot;
      bit          is_cmd;
      len = ptr_dist(ed_ptr, cm_ptr) - 1;
      is_cmd = (len >= 7);
      for (int j = 0; j < 7 && is_cmd; j++)
         if (line_mem[(cm_ptr + j) % BUF_DEPTH] != hist_prefix[j]) is_cmd = 0;
      if (len > 0 && !is_cmd) begin
         slot = h_next % HIST_ENTRIES;
         if (len > LINE_LEN) len = LINE_LEN;
         for (int j = 0; j < len; j++)
            hist_mem[slot][j] = line_mem[(cm_ptr + j) % BUF_DEPTH];
         hist_size[slot] = len;
         h_next = (slot + 1) % HIST_ENTRIES;
         h_cursor = h_next;
         if (h_count < HIST_ENTRIES) h_count++;
         lines_stored++;
      end
      cm_ptr = ed_ptr;
      ready_f = 1;
   endfunction

   function automatic void recall_line(bit up);
      int unsigned idx;
      int unsigned len;
      int unsigned top;
      idx = h_cursor % HIST_ENTRIES;
      if (idx < h_count) begin
         len = hist_size[idx];
         if (len > LINE_LEN) len = LINE_LEN;
         erase_n = ptr_dist(ed_ptr, cm_ptr);
         ed_ptr = cm_ptr;
         for (int j = 0; j < len; j++) begin
            if (ptr_dist(ed_ptr, rd_ptr) >= BUF_DEPTH) break;
            push_echo(hist_mem[idx][j]);
            put_char(hist_mem[idx][j]);
         end
         recalls_done++;
      end
      if (up) begin
         if (idx != 0) idx--;
      end else begin
         top = (h_next + HIST_ENTRIES - 1) % HIST_ENTRIES;
         if (idx != top) idx = (idx + 1) % HIST_ENTRIES;
      end
      h_cursor = idx;
   endfunction

   function automatic void edit_byte(logic [7:0] c);
      if (esc_state == cle_pkg::ESC_SEEN) begin
         esc_state = (c == cle_pkg::CH_LBRK) ? cle_pkg::ESC_BRKT : cle_pkg::ESC_NONE;
         return;
      end
      if (esc_state == cle_pkg::ESC_BRKT) begin
         esc_state = cle_pkg::ESC_NONE;
         if (c == cle_pkg::CH_UP) recall_line(1);
         else if (c == cle_pkg::CH_DOWN) recall_line(0);
         return;
      end
      if (c == cle_pkg::CH_DLE) begin
         dump_f = 1;
      end else if (c == cle_pkg::CH_NAK) begin
         while (ed_ptr != cm_ptr &&
                line_mem[(ed_ptr + PTR_MOD - 1) % BUF_DEPTH] != cle_pkg::CH_LF) begin
            ed_ptr = (ed_ptr + PTR_MOD - 1) % PTR_MOD;
            erase_n++;
         end
      end else if (c == cle_pkg::CH_BS || c == cle_pkg::CH_DEL) begin
         if (ed_ptr != cm_ptr) begin
            ed_ptr = (ed_ptr + PTR_MOD - 1) % PTR_MOD;
            erase_n = 1;
         end
      end else if (c == cle_pkg::CH_ESC) begin
         esc_state = cle_pkg::ESC_SEEN;
      end else if (c != cle_pkg::CH_NUL && ptr_dist(ed_ptr, rd_ptr) < BUF_DEPTH) begin
         if (c == cle_pkg::CH_CR) c = cle_pkg::CH_LF;
         push_echo(c);
         put_char(c);
         if (c == cle_pkg::CH_LF || c == cle_pkg::CH_EOT ||
             ptr_dist(ed_ptr, rd_ptr) == BUF_DEPTH)
            commit_line();
      end
   endfunction

   function automatic void predict_item(logic kind, logic [7:0] rx, logic started);
      editor_rsp_type r;
      logic [7:0]  c;
      int unsigned n;
      int unsigned cnt;
      if (kind) begin
         r = '0;
         if (rd_ptr != cm_ptr) begin
            c = line_mem[rd_ptr % BUF_DEPTH];
            rd_ptr = (rd_ptr + 1) % PTR_MOD;
            r.read_valid = 1;
            if (c == cle_pkg::CH_EOT) begin
               r.read_eof = 1;
               // ^D stays in place for the next read call when this read had started
               if (started) rd_ptr = (rd_ptr + PTR_MOD - 1) % PTR_MOD;
            end else begin
               r.read_byte = c;
            end
         end
         r.last = 1;
         expected_rsps.push_back(r);
         return;
      end
      echo_n = 0;
      erase_n = 0;
      dump_f = 0;
      ready_f = 0;
      edit_byte(rx);
      n = (echo_n + 7) / 8;
      if (n == 0) n = 1;
      for (int k = 0; k < n; k++) begin
         r = '0;
         cnt = 0;
         if (echo_n > k * 8) cnt = (echo_n - k * 8 > 8) ? 8 : echo_n - k * 8;
         for (int j = 0; j < cnt; j++) r.echo_bytes[8*j +: 8] = echo_q[k*8 + j];
         r.echo_count = 4'(cnt);
         if (k == 0) begin
            r.erase_count  = erase_n[7:0];
            r.dump_request = dump_f;
            r.line_ready   = ready_f;
         end
         r.last = (k + 1 == n);
         expected_rsps.push_back(r);
      end
   endfunction

   function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      editor_rsp_type e;
      if (reset) begin
         expected_rsps.delete();
         rd_ptr = 0; cm_ptr = 0; ed_ptr = 0;
         h_next = 0; h_count = 0; h_cursor = 0;
         esc_state = cle_pkg::ESC_NONE;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_rsps.size() == 0) begin
               $error("result item with no prediction waiting");
               fail_count++;
            end else begin
               e = expected_rsps.pop_front();
               check_field("echo_count", 64'(e.echo_count), 64'(rsp_echo_count));
               check_field("echo_bytes", e.echo_bytes, rsp_echo_bytes);
               check_field("erase_count", 64'(e.erase_count), 64'(rsp_erase_count));
               check_field("dump_request", 64'(e.dump_request), 64'(rsp_dump_request));
               check_field("line_ready", 64'(e.line_ready), 64'(rsp_line_ready));
               check_field("read_valid", 64'(e.read_valid), 64'(rsp_read_valid));
               check_field("read_byte", 64'(e.read_byte), 64'(rsp_read_byte));
               check_field("read_eof", 64'(e.read_eof), 64'(rsp_read_eof));
               check_field("last", 64'(e.last), 64'(rsp_last));
            end
         end
         if (req_valid && req_ready) predict_item(req_kind, req_rx_byte, req_read_started);
      end
      pending = expected_rsps.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      results_seen = 0;
      lines_stored = 0;
      recalls_done = 0;
   end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: console line editor testbench
// Drives typed bytes, edits, escape recalls and read requests with random
// gaps and back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int IDLE_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_kind;
   logic [7:0]  req_rx_byte;
   logic        req_read_started;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_echo_count;
   logic [63:0] rsp_echo_bytes;
   logic [7:0]  rsp_erase_count;
   logic        rsp_dump_request;
   logic        rsp_line_ready;
   logic        rsp_read_valid;
   logic [7:0]  rsp_read_byte;
   logic        rsp_read_eof;
   logic        rsp_last;

   int fail_count, pending, results_seen, lines_stored, recalls_done;
   int items_sent;
   int idle_cycles;
   bit no_idle;
   int hold_seq;

   console_line_editor_with_history dut (.*);

   cle_checker chk (
      .clock, .reset, .req_valid, .req_ready, .req_kind, .req_rx_byte,
      .req_read_started, .rsp_valid, .rsp_ready, .rsp_echo_count,
      .rsp_echo_bytes, .rsp_erase_count, .rsp_dump_request, .rsp_line_ready,
      .rsp_read_valid, .rsp_read_byte, .rsp_read_eof, .rsp_last,
      .fail_count, .pending, .results_seen, .lines_stored, .recalls_done
   );

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // receiver: random stalls, plus a long hold-off when requested
   always @(posedge clock) begin
      int hold_left;
      int hold_seen;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         hold_seen = hold_seq;
      end else begin
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 24);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_item(logic kind, logic [7:0] rx, logic started);
      int gap;
      if (!no_idle && $urandom_range(0, 99) < 24) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_rx_byte      <= rx;
      req_read_started <= started;
      // ready seen at the falling edge means the item goes at the next rising edge
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic type_byte(logic [7:0] c);
      send_item(1'b0, c, 1'($urandom_range(0, 1)));
   endtask

   task automatic read_burst(int n, bit mix_started);
      for (int i = 0; i < n; i++)
         send_item(1'b1, 8'($urandom_range(0, 255)),
                   mix_started ? 1'($urandom_range(0, 1)) : 1'b0);
   endtask

   task automatic type_text(string s);
      for (int i = 0; i < s.len(); i++) type_byte(s[i]);
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic random_line();
      int len;
      int pick;
      logic [7:0] term [3];
      term = '{cle_pkg::CH_CR, cle_pkg::CH_LF, cle_pkg::CH_EOT};
      len = $urandom_range(0, 12);
      if ($urandom_range(0, 9) == 0) type_text("history");
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 7) == 0) type_byte(8'($urandom_range(0, 255)));
         else type_byte(8'($urandom_range(8'h20, 8'h7e)));
      end
      pick = $urandom_range(0, 2);
      type_byte(term[pick]);
   endtask

   task automatic random_escape();
      type_byte(cle_pkg::CH_ESC);
      if ($urandom_range(0, 4) == 0) begin
         type_byte(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1)) type_byte(8'($urandom_range(0, 255)));
      end else begin
         type_byte(cle_pkg::CH_LBRK);
         type_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                   : ($urandom_range(0, 1) ? cle_pkg::CH_UP : cle_pkg::CH_DOWN));
      end
   endtask

   task automatic random_edit();
      logic [7:0] kill_keys [3];
      kill_keys = '{cle_pkg::CH_BS, cle_pkg::CH_DEL, cle_pkg::CH_NAK};
      for (int i = 0; i < $urandom_range(1, 6); i++)
         type_byte(8'($urandom_range(8'h61, 8'h7a)));
      type_byte(kill_keys[$urandom_range(0, 2)]);
   endtask

   initial begin
      int sel;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = 1'b0;
      req_rx_byte = 8'h00;
      req_read_started = 1'b0;
      no_idle = 0;
      hold_seq = 0;
      items_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: editing keys, escape forms, eof handling
      type_text("hi\r");
      type_text("ab");
      type_byte(cle_pkg::CH_BS);
      type_byte(cle_pkg::CH_DEL);
      type_byte(cle_pkg::CH_NAK);
      type_byte(cle_pkg::CH_DLE);
      type_byte(cle_pkg::CH_NUL);
      type_byte(8'hFF);
      type_byte(cle_pkg::CH_LF);
      type_byte(cle_pkg::CH_ESC); type_byte(cle_pkg::CH_LBRK); type_byte(cle_pkg::CH_UP);
      type_byte(cle_pkg::CH_ESC); type_byte(cle_pkg::CH_LBRK); type_byte(cle_pkg::CH_DOWN);
      type_byte(cle_pkg::CH_ESC); type_byte(8'h71);
      type_byte(cle_pkg::CH_ESC); type_byte(cle_pkg::CH_LBRK); type_byte(8'h7A);
      type_byte(cle_pkg::CH_EOT);
      read_burst(4, 0);
      send_item(1'b1, 8'h00, 1'b1);
      send_item(1'b1, 8'h00, 1'b0);
      send_item(1'b1, 8'h00, 1'b0);

      // random phase
      while (items_sent < 80) begin
         sel = $urandom_range(0, 99);
         if (sel < 42) random_line();
         else if (sel < 58) read_burst($urandom_range(1, 10), 1);
         else if (sel < 70) random_escape();
         else if (sel < 80) random_edit();
         else if (sel < 88) type_byte(8'($urandom_range(0, 255)));
         else read_burst(20, 0);
      end

      // full buffer: type without reading until it commits on its own, no idling
      no_idle = 1;
      for (int i = 0; i < 132; i++) type_byte(8'($urandom_range(8'h20, 8'h7e)));
      type_byte(cle_pkg::CH_ESC); type_byte(cle_pkg::CH_LBRK); type_byte(cle_pkg::CH_UP);
      no_idle = 0;
      read_burst(48, 0);
      random_escape();

      // long receiver hold-off while items keep coming
      hold_seq++;
      for (int i = 0; i < 3; i++) random_line();
      drain_wait();
      for (int i = 0; i < 2; i++) random_escape();
      read_burst(20, 1);

      drain_wait();
      repeat (200) @(posedge clock);

      $display("Sent %0d items, checked %0d results; %0d lines stored, %0d recalls.",
               items_sent, results_seen, lines_stored, recalls_done);
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
